// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rolling code table checks
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define RRCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define RRCT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/rrct_pkg.sv -----
// ---------------------------------------------------------------------------
// rrct_pkg
// constants, codes and controller/datapath types of the rolling code table
// ---------------------------------------------------------------------------
package rrct_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int KEY_W       = 24;
    localparam int CODE_W      = 16;
    localparam int ENTRY_W     = KEY_W + CODE_W;
    localparam int OP_W        = 2;
    localparam int STAT_W      = 2;
    localparam int IN_DATA_W   = ((KEY_W + CODE_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((CODE_W + CNT_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_GET    = 2'd0;
    localparam logic [OP_W-1:0] OP_SET    = 2'd1;
    localparam logic [OP_W-1:0] OP_FORGET = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic              load;       // take a new word, rewind the pointer
        logic              rd_nxt;     // read the entry after the pointer
        logic              ptr_inc;
        logic              wr_append;
        logic              wr_update;
        logic              wr_shift;
        logic              cnt_inc;
        logic              cnt_dec;
        logic              cnt_clr;
        logic              res_load;
        logic              res_found;
        logic [STAT_W-1:0] res_status;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            at_end;   // pointer has passed the last stored entry
        logic            hit;      // entry just read matches the address
        logic            full;
        logic            last;     // pointer sits on the last stored entry
    } t_dp_stat;

endpackage

// ----- rtl/rrct_ram.sv -----
// ---------------------------------------------------------------------------
// rrct_ram
// generic single write port ram with a registered read port
// ---------------------------------------------------------------------------
module rrct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                 i_wr_data,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                 o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/rrct_datapath.sv -----
// ---------------------------------------------------------------------------
// rrct_datapath
// entry store, search pointer, entry count and result registers
// ---------------------------------------------------------------------------
module rrct_datapath
    import rrct_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [OP_W-1:0]   i_opcode,
    input  logic [KEY_W-1:0]  i_remote_addr,
    input  logic [CODE_W-1:0] i_new_code,
    output t_dp_stat          o_stat,
    output logic [STAT_W-1:0] o_status,
    output logic [CODE_W-1:0] o_found_code,
    output logic [CNT_W-1:0]  o_entry_count
);

    logic [OP_W-1:0]   r_op;
    logic [KEY_W-1:0]  r_addr;
    logic [CODE_W-1:0] r_code;
    logic [CNT_W-1:0]  r_ptr,   n_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [STAT_W-1:0] r_status;
    logic [CODE_W-1:0] r_found;

    logic [CNT_W-1:0]   ptr_nxt;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic [ENTRY_W-1:0] rd_data;
    logic               wr_en;

    assign ptr_nxt = r_ptr + CNT_W'(1);
    assign rd_addr = i_cmd.rd_nxt ? ptr_nxt[ADDR_W-1:0] : r_ptr[ADDR_W-1:0];
    assign wr_en   = i_cmd.wr_append | i_cmd.wr_update | i_cmd.wr_shift;
    assign wr_addr = i_cmd.wr_append ? r_count[ADDR_W-1:0] : r_ptr[ADDR_W-1:0];
    // an entry is the code above the key
    assign wr_data = i_cmd.wr_shift ? rd_data : {r_code, r_addr};

    rrct_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.load) begin
            n_ptr = '0;
        end else if (i_cmd.ptr_inc) begin
            n_ptr = ptr_nxt;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_clr) begin
            n_count = '0;
        end else if (i_cmd.cnt_inc) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_count <= '0;
        end else begin
            r_ptr   <= n_ptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_addr <= i_remote_addr;
            r_code <= i_new_code;
        end
        if (i_cmd.res_load) begin
            r_status <= i_cmd.res_status;
            r_found  <= i_cmd.res_found ? rd_data[ENTRY_W-1:KEY_W] : '0;
        end
    end

    assign o_stat.op     = r_op;
    assign o_stat.at_end = (r_ptr >= r_count);
    assign o_stat.hit    = (rd_data[KEY_W-1:0] == r_addr);
    assign o_stat.full   = (r_count == CNT_W'(MAX_ENTRIES));
    assign o_stat.last   = (ptr_nxt >= r_count);

    assign o_status      = r_status;
    assign o_found_code  = r_found;
    assign o_entry_count = r_count;

endmodule

// ----- rtl/rrct_ctrl.sv -----
// ---------------------------------------------------------------------------
// rrct_ctrl
// sequencer for search, append, update and compaction of the table
// ---------------------------------------------------------------------------
module rrct_ctrl
    import rrct_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [OP_W-1:0] i_opcode,
    input  logic            i_out_ready,
    input  t_dp_stat        i_stat,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output t_dp_cmd         o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_SHCHK = 3'd3;
    localparam logic [2:0] S_SHWR  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_opcode == OP_CLEAR) begin
                        o_cmd.cnt_clr    = 1'b1;
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_OK;
                        n_state          = S_OUT;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                // read at the pointer is issued here, compared next cycle
                if (i_stat.at_end) begin
                    o_cmd.res_load = 1'b1;
                    if (i_stat.op != OP_SET) begin
                        o_cmd.res_status = ST_NOT_FOUND;
                    end else if (i_stat.full) begin
                        o_cmd.res_status = ST_FULL;
                    end else begin
                        o_cmd.wr_append  = 1'b1;
                        o_cmd.cnt_inc    = 1'b1;
                        o_cmd.res_status = ST_OK;
                    end
                    n_state = S_OUT;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (i_stat.hit) begin
                    case (i_stat.op)
                        OP_GET: begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_found  = 1'b1;
                            o_cmd.res_status = ST_OK;
                            n_state          = S_OUT;
                        end
                        OP_SET: begin
                            o_cmd.wr_update  = 1'b1;
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_OK;
                            n_state          = S_OUT;
                        end
                        default: begin
                            n_state = S_SHCHK;
                        end
                    endcase
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_SHCHK: begin
                if (i_stat.last) begin
                    o_cmd.cnt_dec    = 1'b1;
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_OK;
                    n_state          = S_OUT;
                end else begin
                    o_cmd.rd_nxt = 1'b1;
                    n_state      = S_SHWR;
                end
            end
            S_SHWR: begin
                // move the following entry down into the gap
                o_cmd.wr_shift = 1'b1;
                o_cmd.ptr_inc  = 1'b1;
                n_state        = S_SHCHK;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/remote_rolling_code_table.sv -----
// ---------------------------------------------------------------------------
// remote_rolling_code_table
// table of remote addresses with their rolling codes, get/set/forget/clear
// ---------------------------------------------------------------------------
// One word is handled at a time. A get, set or forget searches the table
// linearly from the first entry, each step reading the single entry ram and
// then comparing its registered output. A forget then closes the gap, for
// each later entry a read, then a write one place lower. Clear goes straight
// to the result. The result waits in the output register until taken; no
// new word is accepted until then.
module remote_rolling_code_table
    import rrct_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // remote_addr, new_code
    input  logic [OP_W-1:0]       s_axis_tuser,   // opcode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // found_code, entry_count, zero pad
    output logic [STAT_W-1:0]     m_axis_tuser    // status
);

    t_dp_cmd           cmd;
    t_dp_stat          stat;
    logic [CODE_W-1:0] found_code;
    logic [CNT_W-1:0]  entry_count;

    rrct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_opcode    (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    rrct_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_opcode      (s_axis_tuser),
        .i_remote_addr (s_axis_tdata[KEY_W-1:0]),
        .i_new_code    (s_axis_tdata[KEY_W+CODE_W-1:KEY_W]),
        .o_stat        (stat),
        .o_status      (m_axis_tuser),
        .o_found_code  (found_code),
        .o_entry_count (entry_count)
    );

    assign m_axis_tdata = OUT_DATA_W'({entry_count, found_code});

endmodule

// ----- rtl/rrct_checker.sv -----
// ---------------------------------------------------------------------------
// rrct_checker
// port level checks on the rolling code table, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rrct_checker
    import rrct_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [STAT_W-1:0]     m_axis_tuser
);

    logic [CNT_W-1:0]  chk_count;
    logic [CODE_W-1:0] chk_found;

    assign chk_found = m_axis_tdata[CODE_W-1:0];
    assign chk_count = m_axis_tdata[CODE_W+CNT_W-1:CODE_W];

    `RRCT_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result word changed while stalled")
    `RRCT_ASSERT(a_count_range, m_axis_tvalid |-> chk_count <= CNT_W'(MAX_ENTRIES), "entry count beyond table size")
    `RRCT_ASSERT(a_found_only_ok, m_axis_tvalid && m_axis_tuser != ST_OK |-> chk_found == '0, "code returned on a failed lookup")
    `RRCT_ASSERT(a_one_at_a_time, !(s_axis_tready && m_axis_tvalid), "input taken while a result waits")
    `RRCT_ASSERT_ALWAYS(a_reset_quiet, $past(!i_rst_n) |-> !m_axis_tvalid, "result word right after reset")

endmodule

bind remote_rolling_code_table rrct_checker u_rrct_checker (.*);
